// File: rtl/ocl_pkg.sv
// ----------------------------------------------------------------------------
// Order command line parser package
// Shared widths, command codes and the decoded command record.
// ----------------------------------------------------------------------------
package ocl_pkg;

  localparam int unsigned ValW  = 31;
  localparam int unsigned CharW = 8;

  // Kind of input request.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NEW    = 3'd0,
    CMD_CANCEL = 3'd1,
    CMD_TOP    = 3'd2,
    CMD_BOOK   = 3'd3,
    CMD_EXIT   = 3'd4,
    CMD_REJECT = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ValW-1:0]   order_number;
    logic              side_sell;
    logic [ValW-1:0]   price_ticks;
    logic [ValW-1:0]   quantity;
  } cmd_t;

endpackage

// File: rtl/ocl_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module ocl_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [ocl_pkg::CharW-1:0] char_code_i,
  input  logic                     take_i,
  output logic                     valid_o,
  output logic                     req_type_o,
  output logic [ocl_pkg::CharW-1:0] char_code_o
);
  import ocl_pkg::*;

  logic             valid_q, valid_d;
  logic             req_q;
  logic [CharW-1:0] char_q;
  logic             load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q  <= req_type_i;
      char_q <= char_code_i;
    end
  end

  assign valid_o     = valid_q;
  assign req_type_o  = req_q;
  assign char_code_o = char_q;

endmodule

// File: rtl/ocl_token_parser.sv
// ----------------------------------------------------------------------------
// Token parser
// Splits the line into whitespace tokens, accumulates numbers and decodes
// the command at end of line.
// ----------------------------------------------------------------------------
module ocl_token_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      req_type_i,
  input  logic [ocl_pkg::CharW-1:0] char_code_i,
  output ocl_pkg::cmd_t             cmd_o
);
  import ocl_pkg::*;

  localparam logic [CharW-1:0] CH_B     = 8'h42;
  localparam logic [CharW-1:0] CH_S     = 8'h53;
  localparam logic [CharW-1:0] CH_P     = 8'h50;
  localparam logic [CharW-1:0] CH_X     = 8'h58;
  localparam logic [CharW-1:0] CH_C     = 8'h43;
  localparam logic [CharW-1:0] CH_N     = 8'h4E;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [35:0]      Lim31    = 36'h080000000;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_ID   = 2'd2
  } fault_e;

  typedef struct packed {
    logic sign;
    logic neg;
    logic digit;
    logic junk;
    logic ovf;
  } num_flags_t;

  logic              in_tok_q, in_tok_d;
  logic [2:0]        count_q, count_d;
  logic [1:0]        len_q, len_d;
  logic [CharW-1:0]  first_q, first_d;
  logic [CharW-1:0]  op_q, op_d;
  logic [31:0]       acc_q, acc_d;
  num_flags_t        flags_q, flags_d;
  logic [ValW-1:0]   id_q, id_d;
  logic              side_q, side_d;
  logic [ValW-1:0]   price_q, price_d;
  logic [ValW-1:0]   qty_q, qty_d;
  fault_e            fault_q, fault_d;

  // End-of-token results.
  logic              num_bad, num_weak;
  logic [2:0]        idx;
  logic [CharW-1:0]  et_op;
  fault_e            et_fault;
  logic [ValW-1:0]   et_id, et_price, et_qty;
  logic              et_side;

  // Token character results.
  logic              is_space, is_digit;
  logic [1:0]        len_b;
  num_flags_t        flags_b, tc_flags;
  logic [31:0]       acc_b, tc_acc;
  logic [1:0]        tc_len;
  logic [35:0]       acc_x10;

  // Line results after closing an open token.
  logic [CharW-1:0]  fin_op;
  fault_e            fin_fault;
  logic [ValW-1:0]   fin_id, fin_price, fin_qty;
  logic              fin_side;

  assign is_space = (char_code_i == CH_SPACE) ||
                    ((char_code_i >= CH_TAB) && (char_code_i <= CH_CR));
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);

  always_comb begin
    num_bad  = !flags_q.digit || flags_q.ovf || (!flags_q.neg && acc_q[31]);
    num_weak = flags_q.neg || (acc_q == 32'd0) || flags_q.junk;
    idx      = count_q - 3'd1;
    et_op    = (idx == 3'd0) ? first_q : op_q;
    et_fault = fault_q;
    et_id    = id_q;
    et_side  = side_q;
    et_price = price_q;
    et_qty   = qty_q;
    if (fault_q == FAULT_NONE) begin
      unique case (idx)
        3'd0: begin
          if (len_q != 2'd1) et_fault = FAULT_ZERO;
        end
        3'd1: begin
          if (num_bad || num_weak) et_fault = FAULT_ZERO;
          else et_id = acc_q[ValW-1:0];
        end
        3'd2: begin
          if ((len_q != 2'd1) || ((first_q != CH_B) && (first_q != CH_S))) begin
            et_fault = FAULT_ID;
          end else begin
            et_side = (first_q == CH_S);
          end
        end
        3'd3, 3'd4: begin
          if (num_bad) et_fault = FAULT_ZERO;
          else if (num_weak) et_fault = FAULT_ID;
          else if (idx == 3'd3) et_price = acc_q[ValW-1:0];
          else et_qty = acc_q[ValW-1:0];
        end
        default: ;
      endcase
    end
  end

  // A character that opens a token starts from cleared number state.
  always_comb begin
    if (in_tok_q) begin
      len_b   = len_q;
      flags_b = flags_q;
      acc_b   = acc_q;
    end else begin
      len_b   = 2'd0;
      flags_b = '0;
      acc_b   = 32'd0;
    end
    acc_x10  = ({4'd0, acc_b} << 3) + ({4'd0, acc_b} << 1) + {32'd0, char_code_i[3:0]};
    tc_flags = flags_b;
    tc_acc   = acc_b;
    if (!flags_b.junk) begin
      if (is_digit) begin
        tc_flags.digit = 1'b1;
        if (!flags_b.ovf) begin
          if (acc_x10 > Lim31) tc_flags.ovf = 1'b1;
          else tc_acc = acc_x10[31:0];
        end
      end else if ((len_b == 2'd0) &&
                   ((char_code_i == CH_PLUS) || (char_code_i == CH_MINUS))) begin
        tc_flags.sign = 1'b1;
        if (char_code_i == CH_MINUS) tc_flags.neg = 1'b1;
      end else begin
        tc_flags.junk = 1'b1;
      end
    end
    tc_len = (len_b == 2'd3) ? len_b : len_b + 2'd1;
  end

  always_comb begin
    in_tok_d = in_tok_q;
    count_d  = count_q;
    len_d    = len_q;
    first_d  = first_q;
    op_d     = op_q;
    acc_d    = acc_q;
    flags_d  = flags_q;
    id_d     = id_q;
    side_d   = side_q;
    price_d  = price_q;
    qty_d    = qty_q;
    fault_d  = fault_q;
    if (fire_i) begin
      if (req_type_i == REQ_CHAR) begin
        if (is_space) begin
          if (in_tok_q) begin
            in_tok_d = 1'b0;
            op_d     = et_op;
            fault_d  = et_fault;
            id_d     = et_id;
            side_d   = et_side;
            price_d  = et_price;
            qty_d    = et_qty;
          end
        end else begin
          if (!in_tok_q) begin
            in_tok_d = 1'b1;
            first_d  = char_code_i;
            if (count_q != 3'd7) count_d = count_q + 3'd1;
          end
          len_d   = tc_len;
          flags_d = tc_flags;
          acc_d   = tc_acc;
        end
      end else begin
        // End of line clears the whole line context.
        in_tok_d = 1'b0;
        count_d  = 3'd0;
        len_d    = 2'd0;
        first_d  = '0;
        op_d     = '0;
        acc_d    = 32'd0;
        flags_d  = '0;
        id_d     = '0;
        side_d   = 1'b0;
        price_d  = '0;
        qty_d    = '0;
        fault_d  = FAULT_NONE;
      end
    end
  end

  always_comb begin
    fin_op    = in_tok_q ? et_op    : op_q;
    fin_fault = in_tok_q ? et_fault : fault_q;
    fin_id    = in_tok_q ? et_id    : id_q;
    fin_side  = in_tok_q ? et_side  : side_q;
    fin_price = in_tok_q ? et_price : price_q;
    fin_qty   = in_tok_q ? et_qty   : qty_q;
    cmd_o = '{kind: CMD_REJECT, order_number: '0, side_sell: 1'b0,
              price_ticks: '0, quantity: '0};
    if ((count_q != 3'd0) && (fin_fault != FAULT_ZERO)) begin
      unique case (fin_op)
        CH_P: if (count_q == 3'd1) cmd_o.kind = CMD_TOP;
        CH_B: if (count_q == 3'd1) cmd_o.kind = CMD_BOOK;
        CH_X: if (count_q == 3'd1) cmd_o.kind = CMD_EXIT;
        CH_C: begin
          if (count_q == 3'd2) begin
            cmd_o.kind         = CMD_CANCEL;
            cmd_o.order_number = fin_id;
          end
        end
        CH_N: begin
          if (count_q == 3'd5) begin
            cmd_o.order_number = fin_id;
            if (fin_fault == FAULT_NONE) begin
              cmd_o.kind        = CMD_NEW;
              cmd_o.side_sell   = fin_side;
              cmd_o.price_ticks = fin_price;
              cmd_o.quantity    = fin_qty;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tok_q <= 1'b0;
      count_q  <= 3'd0;
      len_q    <= 2'd0;
      first_q  <= '0;
      op_q     <= '0;
      acc_q    <= 32'd0;
      flags_q  <= '0;
      id_q     <= '0;
      side_q   <= 1'b0;
      price_q  <= '0;
      qty_q    <= '0;
      fault_q  <= FAULT_NONE;
    end else begin
      in_tok_q <= in_tok_d;
      count_q  <= count_d;
      len_q    <= len_d;
      first_q  <= first_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      flags_q  <= flags_d;
      id_q     <= id_d;
      side_q   <= side_d;
      price_q  <= price_d;
      qty_q    <= qty_d;
      fault_q  <= fault_d;
    end
  end

endmodule

// File: rtl/ocl_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded command until the consumer takes it.
// ----------------------------------------------------------------------------
module ocl_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ocl_pkg::cmd_t cmd_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ocl_pkg::cmd_t cmd_o
);
  import ocl_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;

  // The register can take a new command in the cycle the old one leaves.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign out_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// File: rtl/order_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// Order command line parser, top level
// Path: an accepted end-of-line request waits in the input register until the
//   result register is free, then its decoded command loads into the result register.
// Throughput: one request per cycle; the input stalls only while an
//   end-of-line request waits in the input register behind a stalled result.
// Reset: asynchronous, active low; clears all line context and the valid flags of both stages.
// ----------------------------------------------------------------------------
module order_command_line_parser_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [ocl_pkg::CharW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                cmd_kind_o,
  output logic [ocl_pkg::ValW-1:0]  order_number_o,
  output logic                      side_sell_o,
  output logic [ocl_pkg::ValW-1:0]  price_ticks_o,
  output logic [ocl_pkg::ValW-1:0]  quantity_o
);
  import ocl_pkg::*;

  logic             st_valid, st_req, take, out_free;
  logic [CharW-1:0] st_char;
  cmd_t             dec_cmd, res_cmd;

  assign take = st_valid && ((st_req == REQ_CHAR) || out_free);

  ocl_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .take_i      (take),
    .valid_o     (st_valid),
    .req_type_o  (st_req),
    .char_code_o (st_char)
  );

  ocl_token_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .req_type_i  (st_req),
    .char_code_i (st_char),
    .cmd_o       (dec_cmd)
  );

  ocl_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && (st_req == REQ_EOL)),
    .cmd_i       (dec_cmd),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (res_cmd)
  );

  assign cmd_kind_o     = res_cmd.kind;
  assign order_number_o = res_cmd.order_number;
  assign side_sell_o    = res_cmd.side_sell;
  assign price_ticks_o  = res_cmd.price_ticks;
  assign quantity_o     = res_cmd.quantity;

  // A character request never produces a result.
  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (st_req == REQ_CHAR)) |=> (out_valid_o == $past(out_valid_o && out_stall_i)))
    else $error("character request produced a result");

  // An end-of-line request always produces a result.
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (st_req == REQ_EOL)) |=> out_valid_o)
    else $error("end of line lost its result");

  // Only a new order carries side, price and quantity.
  a_non_new_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cmd_kind_o != CMD_NEW)) |->
      (!side_sell_o && (price_ticks_o == '0) && (quantity_o == '0)))
    else $error("order fields set on a command other than new");

  // Book queries and exit carry no order id.
  a_query_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((cmd_kind_o == CMD_TOP) || (cmd_kind_o == CMD_BOOK) ||
                     (cmd_kind_o == CMD_EXIT))) |-> (order_number_o == '0))
    else $error("order id set on a query command");

  // A new order always has positive order id, price and quantity.
  a_new_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cmd_kind_o == CMD_NEW)) |->
      ((price_ticks_o != '0) && (quantity_o != '0) && (order_number_o != '0)))
    else $error("new order with a zero field");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order command line parser testbench
// A clocked driver feeds character and end-of-line requests from a queue.
// Each accepted request updates a line-parsing predictor, and every finished
// line leaves one expected command. A clocked monitor compares each command
// the block returns with the oldest expected one. Both sides insert random
// gaps, and the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

  import ocl_pkg::*;

  localparam logic [7:0] CH_NEW    = "N";
  localparam logic [7:0] CH_CANCEL = "C";
  localparam logic [7:0] CH_TOP    = "P";
  localparam logic [7:0] CH_BOOK   = "B";
  localparam logic [7:0] CH_EXIT   = "X";
  localparam logic [7:0] CH_BUY    = "B";
  localparam logic [7:0] CH_SELL   = "S";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int LongHoldCycles = 400;
  localparam int LongHoldAfter  = 40;

  typedef enum logic [1:0] {FLT_NONE, FLT_NO_ID, FLT_WITH_ID} fault_e;
  typedef enum logic [1:0] {NUM_GOOD, NUM_MALFORMED, NUM_BAD_VALUE} num_e;

  typedef struct {
    logic       eol;
    logic [7:0] code;
  } line_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_CHAR;
  logic [CharW-1:0]  char_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        cmd_kind;
  logic [ValW-1:0]   order_number;
  logic              side_sell;
  logic [ValW-1:0]   price_ticks;
  logic [ValW-1:0]   quantity;

  line_req_t         pending_reqs[$];
  cmd_t              expected_cmds[$];
  line_req_t         tx_req;

  int errors = 0;
  int reqs_accepted = 0;
  int cmds_checked = 0;
  int kind_tally[6];
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // Line context mirrored from the parser.
  logic        tok_open;
  logic [2:0]  tok_total;
  logic [1:0]  tok_len;
  logic [7:0]  tok_head;
  logic [7:0]  opcode;
  logic [31:0] num_mag;
  logic        num_sign, num_neg, num_digit, num_junk, num_ovf;
  logic [30:0] line_id, line_price, line_qty;
  logic        line_sell;
  fault_e      line_fault;

  order_command_line_parser_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .char_code_i   (char_code),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cmd_kind_o    (cmd_kind),
    .order_number_o(order_number),
    .side_sell_o   (side_sell),
    .price_ticks_o (price_ticks),
    .quantity_o    (quantity)
  );

  always #5 clk = ~clk;

  function automatic void clear_line();
    tok_open   = 1'b0;
    tok_total  = '0;
    tok_len    = '0;
    tok_head   = '0;
    opcode     = '0;
    num_mag    = '0;
    num_sign   = 1'b0;
    num_neg    = 1'b0;
    num_digit  = 1'b0;
    num_junk   = 1'b0;
    num_ovf    = 1'b0;
    line_id    = '0;
    line_sell  = 1'b0;
    line_price = '0;
    line_qty   = '0;
    line_fault = FLT_NONE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic num_e classify_number(output logic [30:0] val);
    val = '0;
    if (!num_digit || num_ovf) return NUM_MALFORMED;
    if (!num_neg && num_mag >= 32'h8000_0000) return NUM_MALFORMED;
    if (num_neg || num_mag == 0 || num_junk) return NUM_BAD_VALUE;
    val = num_mag[30:0];
    return NUM_GOOD;
  endfunction

  function automatic void add_token_char(logic [7:0] c);
    logic [63:0] wide;
    if (!num_junk) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num_digit = 1'b1;
        if (!num_ovf) begin
          wide = 64'(num_mag) * 64'd10 + 64'(c - CH_ZERO);
          if (wide > 64'h8000_0000) num_ovf = 1'b1;
          else num_mag = wide[31:0];
        end
      end else if (tok_len == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
        num_sign = 1'b1;
        if (c == CH_MINUS) num_neg = 1'b1;
      end else begin
        num_junk = 1'b1;
      end
    end
    if (tok_len < 2'd3) tok_len++;
  endfunction

  // Evaluates the token that just ended; only the first fault of a line counts.
  function automatic void close_token();
    int          idx;
    num_e        st;
    logic [30:0] v;
    idx = int'(tok_total) - 1;
    tok_open = 1'b0;
    if (idx == 0) opcode = tok_head;
    if (line_fault != FLT_NONE) return;
    case (idx)
      0: if (tok_len != 2'd1) line_fault = FLT_NO_ID;
      1: begin
        st = classify_number(v);
        if (st != NUM_GOOD) line_fault = FLT_NO_ID;
        else line_id = v;
      end
      2: begin
        if (tok_len != 2'd1 || (tok_head != CH_BUY && tok_head != CH_SELL))
          line_fault = FLT_WITH_ID;
        else
          line_sell = (tok_head == CH_SELL);
      end
      3, 4: begin
        st = classify_number(v);
        if (st == NUM_MALFORMED) line_fault = FLT_NO_ID;
        else if (st == NUM_BAD_VALUE) line_fault = FLT_WITH_ID;
        else if (idx == 3) line_price = v;
        else line_qty = v;
      end
      default: ;
    endcase
  endfunction

  function automatic void track_request(logic eol, logic [7:0] c);
    cmd_t want;
    if (eol == REQ_CHAR) begin
      if (is_blank(c)) begin
        if (tok_open) close_token();
      end else begin
        if (!tok_open) begin
          tok_open = 1'b1;
          if (tok_total < 3'd7) tok_total++;
          tok_len   = '0;
          tok_head  = c;
          num_mag   = '0;
          num_sign  = 1'b0;
          num_neg   = 1'b0;
          num_digit = 1'b0;
          num_junk  = 1'b0;
          num_ovf   = 1'b0;
        end
        add_token_char(c);
      end
      return;
    end
    if (tok_open) close_token();
    want = '0;
    want.kind = CMD_REJECT;
    if (tok_total != 0 && line_fault != FLT_NO_ID) begin
      case (opcode)
        CH_TOP:  if (tok_total == 3'd1) want.kind = CMD_TOP;
        CH_BOOK: if (tok_total == 3'd1) want.kind = CMD_BOOK;
        CH_EXIT: if (tok_total == 3'd1) want.kind = CMD_EXIT;
        CH_CANCEL: begin
          if (tok_total == 3'd2) begin
            want.kind = CMD_CANCEL;
            want.order_number = line_id;
          end
        end
        CH_NEW: begin
          if (tok_total == 3'd5) begin
            want.order_number = line_id;
            if (line_fault == FLT_NONE) begin
              want.kind        = CMD_NEW;
              want.side_sell   = line_sell;
              want.price_ticks = line_price;
              want.quantity    = line_qty;
            end
          end
        end
        default: ;
      endcase
    end
    expected_cmds.insert(expected_cmds.size(), want);
    clear_line();
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_char(logic [7:0] c);
    line_req_t r;
    r.eol  = REQ_CHAR;
    r.code = c;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_eol();
    line_req_t r;
    r.eol  = REQ_EOL;
    r.code = 8'($urandom_range(0, 255));
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_line(string s);
    push_text(s);
    push_eol();
  endtask

  task automatic push_gap();
    logic [7:0] blanks[6];
    blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    repeat ($urandom_range(1, 2)) push_char(blanks[$urandom_range(0, 5)]);
  endtask

  task automatic push_number();
    int          pick;
    int unsigned lim;
    pick = $urandom_range(0, 39);
    case (pick)
      0: push_text("0");
      1: push_text($sformatf("-%0d", $urandom_range(0, 2147483647)));
      2: push_text($sformatf("%0d", 32'h8000_0000 + $urandom_range(0, 9999)));
      3: push_text("99999999999");
      4: push_text($sformatf("%0dx", $urandom_range(1, 99999)));
      5: push_text($urandom_range(0, 1) ? "+" : "-");
      6: push_text($sformatf("+%0d", $urandom_range(1, 2147483647)));
      7: push_text("2147483647");
      8: push_text("-2147483648");
      9: push_text($sformatf("00%0d", $urandom_range(1, 999)));
      default: begin
        if (pick >= 36) begin
          push_text($sformatf("%0d", $urandom_range(1, 2147483647)));
        end else begin
          lim = 1;
          repeat ($urandom_range(1, 9)) lim = lim * 10;
          push_text($sformatf("%0d", $urandom_range(1, lim - 1)));
        end
      end
    endcase
  endtask

  task automatic push_side();
    case ($urandom_range(0, 11))
      0: push_text("BS");
      1: push_text("b");
      2: push_char(8'($urandom_range(33, 126)));
      default: push_char($urandom_range(0, 1) ? CH_SELL : CH_BUY);
    endcase
  endtask

  task automatic push_opcode();
    case ($urandom_range(0, 7))
      0: push_char(CH_NEW);
      1: push_char(CH_CANCEL);
      2: push_char(CH_TOP);
      3: push_char(CH_BOOK);
      4: push_char(CH_EXIT);
      5: push_text("PP");
      6: push_text("NC");
      default: push_char(8'($urandom_range(33, 126)));
    endcase
  endtask

  task automatic push_random_line();
    int shape;
    int ntok;
    shape = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) push_gap();
    if (shape < 7) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          push_char(CH_NEW);
          push_gap(); push_number();
          push_gap(); push_side();
          push_gap(); push_number();
          push_gap(); push_number();
        end
        2: begin
          push_char(CH_CANCEL);
          push_gap(); push_number();
        end
        3: push_char(CH_TOP);
        4: push_char(CH_BOOK);
        default: push_char(CH_EXIT);
      endcase
    end else if (shape < 9) begin
      // Broken line: any opcode with any token count, up to past saturation.
      ntok = $urandom_range(0, 9);
      for (int i = 0; i < ntok; i++) begin
        if (i != 0) push_gap();
        if (i == 0) push_opcode();
        else if ($urandom_range(0, 1) != 0) push_number();
        else push_side();
      end
    end else begin
      repeat ($urandom_range(0, 12)) push_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) push_gap();
    push_eol();
  endtask

  task automatic queue_directed();
    push_line("");
    push_line("P");
    push_line("B");
    push_line("X");
    push_line("C 42");
    push_line("C +12");
    push_line("N 7 B 100 25");
    push_line("N 2147483647 S 2147483647 2147483647");
    push_line("PP");
    push_line("Q");
    push_line("P 1");
    push_line("C 2147483648");
    push_line("C -2147483648");
    push_line("C 0");
    push_line("C 12x");
    push_line("C 99999999999x");
    push_line("C +");
    push_line("N 5 Z 10 10");
    push_line("N 5 BB 10 10");
    push_line("N 5 S 0 10");
    push_line("N 5 S 10 -3");
    push_line("N 5 S 99999999999 1");
    push_line("N 6 B 10x 1");
    push_line("N 5 Q 99999999999 1");
    push_line("N 1 B 1 1 extra more more more more");
    push_line("NNNNN 1 B 1 1");
    // Every whitespace byte separates tokens, and a line feed is not an end.
    push_char(CH_TAB); push_char(CH_NEW); push_char(CH_LF); push_text("3");
    push_char(CH_VT); push_char(CH_SELL); push_char(CH_FF); push_text("4");
    push_char(CH_CR); push_text(" 5 ");
    push_eol();
    push_char(8'h00); push_eol();
    push_char(8'hFF); push_eol();
  endtask

  // ------------------------------------------------------------ driver/monitor

  function automatic int pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(req_type, char_code);
        reqs_accepted++;
        tx_wait = pick_wait(tx_calm);
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
      end
      // A stalled request holds its payload until it is taken.
      if (!(in_valid && in_stall)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          tx_req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_type  <= tx_req.eol;
          char_code <= tx_req.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [30:0] want, logic [30:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cmd_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected command, expected none, actual kind %0d id %0d",
                   $time, cmd_kind, order_number);
        end else begin
          want = expected_cmds.pop_front();
          compare_field("cmd_kind", 31'(want.kind), 31'(cmd_kind));
          compare_field("order_number", want.order_number, order_number);
          compare_field("side_sell", 31'(want.side_sell), 31'(side_sell));
          compare_field("price_ticks", want.price_ticks, price_ticks);
          compare_field("quantity", want.quantity, quantity);
        end
        if (cmd_kind <= 3'd5) kind_tally[cmd_kind]++;
        cmds_checked++;
        rx_wait = pick_wait(rx_calm);
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        // One long hold so the block backs up and stalls its input.
        if (cmds_checked == LongHoldAfter) rx_wait = LongHoldCycles;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------- control

  initial begin
    clear_line();
    queue_directed();
    while (pending_reqs.size() < 1250) push_random_line();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pending_reqs.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Covered %0d requests and %0d commands: %0d new, %0d cancel, %0d reject.",
             reqs_accepted, cmds_checked, kind_tally[CMD_NEW], kind_tally[CMD_CANCEL],
             kind_tally[CMD_REJECT]);
    $display("Top %0d, book %0d, exit %0d; %0d mismatches.",
             kind_tally[CMD_TOP], kind_tally[CMD_BOOK], kind_tally[CMD_EXIT], errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timed out with %0d commands outstanding", $time, expected_cmds.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
